>>> hdl/lgx_pkg.sv
// Shared types and constants for the Lagrange extrapolation block.
package lgx_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_COUNT  = 2'd1,
    ST_COINCIDENT = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  localparam logic [1:0] PC_LINE     = 2'd2;
  localparam logic [1:0] PC_PARABOLA = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] pc;
    status_t    st;
  } side_t;

endpackage

>>> hdl/lgx_if.sv
// Channel interfaces for input samples and result coefficients.
interface lgx_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] y_first;
  logic signed [DATA_WIDTH-1:0] y_second;
  logic signed [DATA_WIDTH-1:0] y_third;
  logic signed [DATA_WIDTH-1:0] x_first;
  logic signed [DATA_WIDTH-1:0] x_second;
  logic signed [DATA_WIDTH-1:0] x_third;
  logic signed [DATA_WIDTH-1:0] x_target;
  modport source (output valid, y_first, y_second, y_third, x_first, x_second, x_third,
                  x_target, input ready);
  modport sink (input valid, y_first, y_second, y_third, x_first, x_second, x_third,
                x_target, output ready);
endinterface

interface lgx_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value_at_target;
  logic signed [DATA_WIDTH-1:0] slope;
  logic signed [DATA_WIDTH-1:0] curvature;
  logic [1:0]                   status;
  modport source (output valid, value_at_target, slope, curvature, status, input ready);
  modport sink (input valid, value_at_target, slope, curvature, status, output ready);
endinterface

>>> hdl/lgx_div.sv
// Pipelined wide multiplier and restoring divider with rounding and saturation to the output range.
module lgx_mul #(
  parameter int AW = 66,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW  = AW + BW;
  localparam int CW  = 32;
  localparam int NCH = (AW + CW - 1) / CW;
  localparam int XW  = NCH * CW;
  localparam int QW  = CW + 1 + BW;

  logic signed [XW-1:0] ax;
  logic signed [QW-1:0] pp [0:NCH-1];
  logic signed [PW-1:0] sum;

  assign ax = XW'(a);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCH - 1; k++) begin
        pp[k] <= QW'($signed({1'b0, ax[k*CW +: CW]})) * QW'(b);
      end
      pp[NCH-1] <= QW'($signed(ax[XW-1 -: CW])) * QW'(b);
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < NCH; k++) begin
      sum = sum + (PW'(pp[k]) <<< (k * CW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum;
    end
  end

endmodule

module lgx_div #(
  parameter int DATA_WIDTH = 32,
  parameter int NUM_WIDTH  = 136,
  parameter int DEN_WIDTH  = 99
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NUM_WIDTH-1:0]         num,
  input  logic [DEN_WIDTH-1:0]         den,
  input  logic                         neg,
  output logic signed [DATA_WIDTH-1:0] quo,
  output logic                         sat
);

  localparam int W = DATA_WIDTH;

  logic [NUM_WIDTH-1:0] rem [0:W];
  logic [W-1:0]         qq  [0:W];
  logic [DEN_WIDTH-1:0] dn  [0:W];
  logic                 ng  [0:W];
  logic                 ov  [0:W];
  logic [NUM_WIDTH-1:0] shd [0:W-1];
  logic                 ge  [0:W-1];

  for (genvar k = 0; k < W; k++) begin : g_step
    assign shd[k] = NUM_WIDTH'(dn[k]) << (W - 1 - k);
    assign ge[k]  = rem[k] >= shd[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dn[0]  <= den;
      ng[0]  <= neg;
      ov[0]  <= num >= (NUM_WIDTH'(den) << W);
      qq[0]  <= '0;
      for (int k = 0; k < W; k++) begin
        rem[k+1] <= ge[k] ? (rem[k] - shd[k]) : rem[k];
        qq[k+1]  <= ge[k] ? (qq[k] | (W'(1) << (W - 1 - k))) : qq[k];
        dn[k+1]  <= dn[k];
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  logic         rup;
  logic [W:0]   qr;
  logic [W:0]   half;
  logic         sat_pos;
  logic         sat_neg;

  assign rup     = {rem[W], 1'b0} >= (NUM_WIDTH + 1)'(dn[W]);
  assign qr      = {1'b0, qq[W]} + (W + 1)'(rup);
  assign half    = (W + 1)'(1) << (W - 1);
  assign sat_pos = !ng[W] && (ov[W] || qr >= half);
  assign sat_neg = ng[W] && (ov[W] || qr > half);

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= sat_pos || sat_neg;
      if (sat_pos) begin
        quo <= {1'b0, {(W - 1){1'b1}}};
      end else if (sat_neg) begin
        quo <= {1'b1, {(W - 1){1'b0}}};
      end else if (ng[W]) begin
        quo <= W'(-qr);
      end else begin
        quo <= W'(qr);
      end
    end
  end

endmodule

>>> hdl/lagrange_extrapolate_to_target.sv
// Top level of the Lagrange extrapolation block.
//
// Each transaction on in_ch carries two or three (x, y) points and a target x.
// Each transaction on out_ch returns the value, slope and curvature of the
// line or parabola through the points, taken about the target, and a status.
// cfg_we and cfg_data write the register pc, selecting a line (2) or a
// parabola (3), by the user only while the block is idle; nothing checks it.
// Seven arithmetic stages build the numerators and the common denominator,
// the second and third levels of wide products taking two of them each, and
// a divider that resolves one quotient bit per stage finishes the three
// coefficients in parallel.
// Throughput is one transaction per cycle while the receiver does not stall.
// Synchronous reset empties the pipeline and sets pc to 3.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops; nothing is lost or repeated.
module lagrange_extrapolate_to_target #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  lgx_in_if.sink     in_ch,
  lgx_out_if.source  out_ch
);

  localparam int W    = DATA_WIDTH;
  localparam int W1   = W + 1;
  localparam int P2   = 2 * W + 2;
  localparam int P3   = 3 * W + 3;
  localparam int P4   = 4 * W + 4;
  localparam int NA   = 4 * W + 6;
  localparam int NB   = 3 * W + 6 + FRAC_BITS;
  localparam int NC   = 2 * W + 5 + 2 * FRAC_BITS;
  localparam int NMAX = (NA > NB) ? ((NA > NC) ? NA : NC) : ((NB > NC) ? NB : NC);
  localparam int NW   = NMAX + 1;
  localparam int DW   = P3;
  localparam int DLAT = W + 2;

  logic [1:0] pc;
  logic       en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lgx_pkg::PC_PARABOLA;
    end else if (cfg_we) begin
      pc <= cfg_data;
    end
  end

  lgx_pkg::side_t s1, s2, s3, s4, s5, s6, s7;
  lgx_pkg::side_t side [0:DLAT-1];

  assign en           = !side[DLAT-1].valid || out_ch.ready;
  assign in_ch.ready  = en;

  logic signed [W1-1:0] x12, x13, x23;
  lgx_pkg::status_t     st_in;

  assign x12 = W1'(in_ch.x_first) - W1'(in_ch.x_second);
  assign x13 = W1'(in_ch.x_first) - W1'(in_ch.x_third);
  assign x23 = W1'(in_ch.x_second) - W1'(in_ch.x_third);

  always_comb begin
    case (pc)
      lgx_pkg::PC_LINE: begin
        st_in = (x12 == '0) ? lgx_pkg::ST_COINCIDENT : lgx_pkg::ST_OK;
      end
      lgx_pkg::PC_PARABOLA: begin
        st_in = (x12 == '0 || x13 == '0 || x23 == '0) ? lgx_pkg::ST_COINCIDENT
                                                       : lgx_pkg::ST_OK;
      end
      default: begin
        st_in = lgx_pkg::ST_BAD_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      s5.valid <= 1'b0;
      s6.valid <= 1'b0;
      s7.valid <= 1'b0;
      for (int i = 0; i < DLAT; i++) begin
        side[i].valid <= 1'b0;
      end
    end else if (en) begin
      s1.valid <= in_ch.valid;
      s1.pc    <= pc;
      s1.st    <= st_in;
      s2       <= s1;
      s3       <= s2;
      s4       <= s3;
      s5       <= s4;
      s6       <= s5;
      s7       <= s6;
      side[0]  <= s7;
      for (int i = 1; i < DLAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // Stage 1: offsets from the target and differences.
  logic signed [W-1:0]  y1_1, y2_1, y3_1;
  logic signed [W1-1:0] d1_1, d2_1, d3_1, e12_1, e13_1, e23_1, y21_1, y32_1, y13_1;

  always_ff @(posedge clk) begin
    if (en) begin
      y1_1  <= in_ch.y_first;
      y2_1  <= in_ch.y_second;
      y3_1  <= in_ch.y_third;
      d1_1  <= W1'(in_ch.x_first) - W1'(in_ch.x_target);
      d2_1  <= W1'(in_ch.x_second) - W1'(in_ch.x_target);
      d3_1  <= W1'(in_ch.x_third) - W1'(in_ch.x_target);
      e12_1 <= x12;
      e13_1 <= x13;
      e23_1 <= x23;
      y21_1 <= W1'(in_ch.y_second) - W1'(in_ch.y_first);
      y32_1 <= W1'(in_ch.y_third) - W1'(in_ch.y_second);
      y13_1 <= W1'(in_ch.y_first) - W1'(in_ch.y_third);
    end
  end

  // Stage 2: first products.
  logic signed [P2-1:0] pe_2, a1_2, a2_2, a3_2, q1_2, q2_2, q3_2, m1_2, m2_2, m3_2;
  logic signed [W1-1:0] d2_2, d3_2, e12_2, e13_2, e23_2, y21_2, y32_2, y13_2;

  always_ff @(posedge clk) begin
    if (en) begin
      pe_2  <= e12_1 * e13_1;
      a1_2  <= W1'(y1_1) * d2_1;
      a2_2  <= W1'(y2_1) * d1_1;
      a3_2  <= W1'(y3_1) * d1_1;
      q1_2  <= d1_1 * d1_1;
      q2_2  <= d2_1 * d2_1;
      q3_2  <= d3_1 * d3_1;
      m1_2  <= d3_1 * y21_1;
      m2_2  <= d2_1 * y13_1;
      m3_2  <= d1_1 * y32_1;
      d2_2  <= d2_1;
      d3_2  <= d3_1;
      e12_2 <= e12_1;
      e13_2 <= e13_1;
      e23_2 <= e23_1;
      y21_2 <= y21_1;
      y32_2 <= y32_1;
      y13_2 <= y13_1;
    end
  end

  // Stage 3: second products and the curvature numerator.
  logic signed [P3-1:0]   prod_3, b1_3, b2_3, b3_3, r1_3, r2_3, r3_3;
  logic signed [P2+1:0]   n2_m3, n2_3;
  logic signed [P2-1:0]   a1_m3, a2_m3, a1_3, a2_3;
  logic signed [W1-1:0]   e12_m3, e13_m3, e23_m3, y21_m3;
  logic signed [W1-1:0]   e12_3, e13_3, e23_3, y21_3;

  lgx_mul #(.AW(P2), .BW(W1)) u_mul_prod (
    .clk(clk), .en(en), .a(pe_2), .b(e23_2), .p(prod_3)
  );
  lgx_mul #(.AW(P2), .BW(W1)) u_mul_b1 (
    .clk(clk), .en(en), .a(a1_2), .b(d3_2), .p(b1_3)
  );
  lgx_mul #(.AW(P2), .BW(W1)) u_mul_b2 (
    .clk(clk), .en(en), .a(a2_2), .b(d3_2), .p(b2_3)
  );
  lgx_mul #(.AW(P2), .BW(W1)) u_mul_b3 (
    .clk(clk), .en(en), .a(a3_2), .b(d2_2), .p(b3_3)
  );
  lgx_mul #(.AW(P2), .BW(W1)) u_mul_r1 (
    .clk(clk), .en(en), .a(q3_2), .b(y21_2), .p(r1_3)
  );
  lgx_mul #(.AW(P2), .BW(W1)) u_mul_r2 (
    .clk(clk), .en(en), .a(q1_2), .b(y32_2), .p(r2_3)
  );
  lgx_mul #(.AW(P2), .BW(W1)) u_mul_r3 (
    .clk(clk), .en(en), .a(q2_2), .b(y13_2), .p(r3_3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      n2_m3  <= (P2 + 2)'(m1_2) + (P2 + 2)'(m2_2) + (P2 + 2)'(m3_2);
      a1_m3  <= a1_2;
      a2_m3  <= a2_2;
      e12_m3 <= e12_2;
      e13_m3 <= e13_2;
      e23_m3 <= e23_2;
      y21_m3 <= y21_2;
      n2_3   <= n2_m3;
      a1_3   <= a1_m3;
      a2_3   <= a2_m3;
      e12_3  <= e12_m3;
      e13_3  <= e13_m3;
      e23_3  <= e23_m3;
      y21_3  <= y21_m3;
    end
  end

  // Stage 4: third products and the slope numerator.
  logic signed [P4-1:0]   t1_4, t2_4, t3_4;
  logic signed [P3+1:0]   n1_m4, n1_4;
  logic signed [P3-1:0]   prod_m4, prod_4;
  logic signed [P2+1:0]   n2_m4, n2_4;
  logic signed [P2-1:0]   a1_m4, a2_m4, a1_4, a2_4;
  logic signed [W1-1:0]   e12_m4, y21_m4, e12_4, y21_4;

  lgx_mul #(.AW(P3), .BW(W1)) u_mul_t1 (
    .clk(clk), .en(en), .a(b1_3), .b(e23_3), .p(t1_4)
  );
  lgx_mul #(.AW(P3), .BW(W1)) u_mul_t2 (
    .clk(clk), .en(en), .a(b2_3), .b(e13_3), .p(t2_4)
  );
  lgx_mul #(.AW(P3), .BW(W1)) u_mul_t3 (
    .clk(clk), .en(en), .a(b3_3), .b(e12_3), .p(t3_4)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      n1_m4   <= -((P3 + 2)'(r1_3) + (P3 + 2)'(r2_3) + (P3 + 2)'(r3_3));
      prod_m4 <= prod_3;
      n2_m4   <= n2_3;
      a1_m4   <= a1_3;
      a2_m4   <= a2_3;
      e12_m4  <= e12_3;
      y21_m4  <= y21_3;
      n1_4    <= n1_m4;
      prod_4  <= prod_m4;
      n2_4    <= n2_m4;
      a1_4    <= a1_m4;
      a2_4    <= a2_m4;
      e12_4   <= e12_m4;
      y21_4   <= y21_m4;
    end
  end

  // Stage 5: value numerator.
  logic signed [NA-1:0]   n0_5;
  logic signed [P3+1:0]   n1_5;
  logic signed [P3-1:0]   prod_5;
  logic signed [P2+1:0]   n2_5;
  logic signed [P2-1:0]   a1_5, a2_5;
  logic signed [W1-1:0]   e12_5, y21_5;

  always_ff @(posedge clk) begin
    if (en) begin
      n0_5   <= NA'(t1_4) - NA'(t2_4) + NA'(t3_4);
      n1_5   <= n1_4;
      prod_5 <= prod_4;
      n2_5   <= n2_4;
      a1_5   <= a1_4;
      a2_5   <= a2_4;
      e12_5  <= e12_4;
      y21_5  <= y21_4;
    end
  end

  logic signed [NW-1:0] num0, num1, num2;
  logic signed [DW-1:0] dens;
  logic [NW-1:0]        mag0, mag1, mag2;
  logic [DW-1:0]        dmag;
  logic                 neg0, neg1, neg2;

  always_comb begin
    if (s7.pc == lgx_pkg::PC_LINE) begin
      num0 = NW'(a1_5) - NW'(a2_5);
      num1 = NW'(y21_5) <<< FRAC_BITS;
      num2 = '0;
      dens = -DW'(e12_5);
    end else begin
      num0 = NW'(n0_5);
      num1 = NW'(n1_5) <<< FRAC_BITS;
      num2 = NW'(n2_5) <<< (2 * FRAC_BITS);
      dens = prod_5;
    end
  end

  assign mag0 = num0[NW-1] ? NW'(-num0) : NW'(num0);
  assign mag1 = num1[NW-1] ? NW'(-num1) : NW'(num1);
  assign mag2 = num2[NW-1] ? NW'(-num2) : NW'(num2);
  assign dmag = dens[DW-1] ? DW'(-dens) : DW'(dens);
  assign neg0 = num0[NW-1] ^ dens[DW-1];
  assign neg1 = num1[NW-1] ^ dens[DW-1];
  assign neg2 = num2[NW-1] ^ dens[DW-1];

  logic signed [W-1:0] c0, c1, c2;
  logic                sat0, sat1, sat2;

  lgx_div #(.DATA_WIDTH(W), .NUM_WIDTH(NW), .DEN_WIDTH(DW)) u_div0 (
    .clk(clk), .en(en), .num(mag0), .den(dmag), .neg(neg0), .quo(c0), .sat(sat0)
  );
  lgx_div #(.DATA_WIDTH(W), .NUM_WIDTH(NW), .DEN_WIDTH(DW)) u_div1 (
    .clk(clk), .en(en), .num(mag1), .den(dmag), .neg(neg1), .quo(c1), .sat(sat1)
  );
  lgx_div #(.DATA_WIDTH(W), .NUM_WIDTH(NW), .DEN_WIDTH(DW)) u_div2 (
    .clk(clk), .en(en), .num(mag2), .den(dmag), .neg(neg2), .quo(c2), .sat(sat2)
  );

  logic fine;
  assign fine = side[DLAT-1].st == lgx_pkg::ST_OK;

  assign out_ch.valid           = side[DLAT-1].valid;
  assign out_ch.value_at_target = fine ? c0 : '0;
  assign out_ch.slope           = fine ? c1 : '0;
  assign out_ch.curvature       = (fine && side[DLAT-1].pc == lgx_pkg::PC_PARABOLA) ? c2 : '0;

  always_comb begin
    if (!fine) begin
      out_ch.status = side[DLAT-1].st;
    end else if (sat0 || sat1 || (sat2 && side[DLAT-1].pc == lgx_pkg::PC_PARABOLA)) begin
      out_ch.status = lgx_pkg::ST_SATURATED;
    end else begin
      out_ch.status = lgx_pkg::ST_OK;
    end
  end

endmodule
